// ----- src/scf_pkg.sv -----
`default_nettype none

package scf_pkg;

	localparam logic [1:0] OP_KEY   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_IGNORED = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_READ    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	localparam logic [1:0] CMD_IGNORE = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] ch;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] character;
		logic [7:0] fill_count;
	} res_t;

	// set-1 make code to US ASCII; zero means no character
	function automatic logic [6:0] key_ascii(input logic [6:0] code);
		logic [6:0] c;
		unique case (code)
			7'd1:  c = 7'h1B;
			7'd2:  c = 7'h31;
			7'd3:  c = 7'h32;
			7'd4:  c = 7'h33;
			7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;
			7'd7:  c = 7'h36;
			7'd8:  c = 7'h37;
			7'd9:  c = 7'h38;
			7'd10: c = 7'h39;
			7'd11: c = 7'h30;
			7'd12: c = 7'h2D;
			7'd13: c = 7'h3D;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h71;
			7'd17: c = 7'h77;
			7'd18: c = 7'h65;
			7'd19: c = 7'h72;
			7'd20: c = 7'h74;
			7'd21: c = 7'h79;
			7'd22: c = 7'h75;
			7'd23: c = 7'h69;
			7'd24: c = 7'h6F;
			7'd25: c = 7'h70;
			7'd26: c = 7'h5B;
			7'd27: c = 7'h5D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h61;
			7'd31: c = 7'h73;
			7'd32: c = 7'h64;
			7'd33: c = 7'h66;
			7'd34: c = 7'h67;
			7'd35: c = 7'h68;
			7'd36: c = 7'h6A;
			7'd37: c = 7'h6B;
			7'd38: c = 7'h6C;
			7'd39: c = 7'h3B;
			7'd40: c = 7'h27;
			7'd41: c = 7'h60;
			7'd43: c = 7'h5C;
			7'd44: c = 7'h7A;
			7'd45: c = 7'h78;
			7'd46: c = 7'h63;
			7'd47: c = 7'h76;
			7'd48: c = 7'h62;
			7'd49: c = 7'h6E;
			7'd50: c = 7'h6D;
			7'd51: c = 7'h2C;
			7'd52: c = 7'h2E;
			7'd53: c = 7'h2F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			7'd74: c = 7'h2D;
			7'd78: c = 7'h2B;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/scancode_ascii_fifo.sv -----
`default_nettype none

// Keyboard scancode to ASCII queue. Each input transaction is a set-1 scancode
// (op 0), a read (op 1) or a clear (op 2); each gives exactly one result
// transaction with a status, the popped character on a good read, and the
// number of characters held afterwards. The ring has DEPTH slots and holds up
// to DEPTH-1 characters. Sustained rate is one transaction per clock while the
// result queue has room: the front classifies through the key table into a
// two-entry command queue, the back does one ring access per clock (memory
// read registered), and a four-entry result queue decouples the output.
// Accepted inputs pass the command queue, stage two and the result queue.
// No clearing pass after reset; entries are only read after being written.
module scancode_ascii_fifo #(
	parameter int DEPTH = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [1:0] op,
	input  wire logic [7:0] scancode,
	output logic            empty,
	input  wire logic       pop,
	output logic [2:0]      status,
	output logic [6:0]      character,
	output logic [7:0]      fill_count
);
	import scf_pkg::*;

	cmd_t  cmd;
	logic  cmd_valid;
	logic  cmd_take;
	res_t  res;
	logic  res_valid;
	res_t  head;
	logic [$clog2(RES_DEPTH):0] res_count;

	scf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.op        (op),
		.scancode  (scancode),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	scf_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_count (res_count),
		.res_valid (res_valid),
		.res       (res)
	);

	scf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_count (res_count),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign status     = head.status;
	assign character  = head.character;
	assign fill_count = head.fill_count;

	localparam logic [7:0] FULL_FILL = 8'((DEPTH - 1) % 256);

	a_store_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.kind == CMD_STORE |-> cmd.ch != 7'd0)
		else $error("store command without a character");

	a_char_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != ST_READ |-> character == 7'd0)
		else $error("character on a non-read result");

	a_read_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == ST_READ |-> character != 7'd0)
		else $error("read returned a zero character");

	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == ST_FULL |-> fill_count == FULL_FILL)
		else $error("dropped-full result with ring not full");

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_count < ($clog2(RES_DEPTH) + 1)'(RES_DEPTH)
			|| (pop && !empty))
		else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- src/scf_front.sv -----
`default_nettype none

module scf_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [1:0]    op,
	input  wire logic [7:0]    scancode,
	output logic               full,
	output logic               cmd_valid,
	output scf_pkg::cmd_t      cmd,
	input  wire logic          cmd_take
);
	import scf_pkg::*;

	cmd_t       new_cmd;
	logic [6:0] key_ch;
	cmd_t       q_q [2];
	logic       head_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;
	logic       wr_idx;

	assign key_ch = key_ascii(scancode[6:0]);

	always_comb begin
		new_cmd.ch   = key_ch;
		new_cmd.kind = CMD_IGNORE;
		unique case (op)
			OP_KEY: begin
				if (!scancode[7] && key_ch != 7'd0)
					new_cmd.kind = CMD_STORE;
			end
			OP_READ:  new_cmd.kind = CMD_READ;
			OP_CLEAR: new_cmd.kind = CMD_CLEAR;
			default:  new_cmd.kind = CMD_IGNORE;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = q_q[head_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_take;
	assign wr_idx    = head_q ^ count_q[0];

	always_ff @(posedge clk) begin
		if (do_push)
			q_q[wr_idx] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_pop)
				head_q <= ~head_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire

// ----- src/scf_back.sv -----
`default_nettype none

module scf_back #(
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cmd_valid,
	input  wire scf_pkg::cmd_t            cmd,
	output logic                          cmd_take,
	input  wire logic [$clog2(scf_pkg::RES_DEPTH):0] res_count,
	output logic                          res_valid,
	output scf_pkg::res_t                 res
);
	import scf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW:0] DEPTH_V = (PW + 1)'(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam int CW = $clog2(RES_DEPTH) + 1;

	logic [6:0]    mem [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW-1:0] wp_d, rp_d;
	logic [PW-1:0] wp_nxt, rp_nxt;
	logic [2:0]    status_d;
	logic          issue;
	logic          mem_we;
	logic          valid_s2;
	logic          is_read_s2;
	logic [2:0]    status_s2;
	logic [PW-1:0] fill_s2;
	logic [6:0]    rdata_s2;
	logic [PW:0]   diff;
	logic [PW-1:0] fill_d;
	logic [PW+7:0] fill_ext;

	assign wp_nxt = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign rp_nxt = (rp_q == LAST) ? '0 : rp_q + 1'b1;

	// hold back unless the result queue has room for this and the one in flight
	assign issue    = cmd_valid && ((res_count + CW'(valid_s2)) < CW'(RES_DEPTH));
	assign cmd_take = issue;

	always_comb begin
		wp_d     = wp_q;
		rp_d     = rp_q;
		mem_we   = 1'b0;
		status_d = ST_IGNORED;
		unique case (cmd.kind)
			CMD_STORE: begin
				if (wp_nxt != rp_q) begin
					mem_we   = 1'b1;
					wp_d     = wp_nxt;
					status_d = ST_STORED;
				end else begin
					status_d = ST_FULL;
				end
			end
			CMD_READ: begin
				if (rp_q == wp_q) begin
					status_d = ST_EMPTY;
				end else begin
					rp_d     = rp_nxt;
					status_d = ST_READ;
				end
			end
			CMD_CLEAR: begin
				wp_d     = '0;
				rp_d     = '0;
				status_d = ST_STORED;
			end
			default: status_d = ST_IGNORED;
		endcase
	end

	always_comb begin
		diff = {1'b0, wp_d} - {1'b0, rp_d};
		if (wp_d < rp_d)
			diff = diff + DEPTH_V;
		fill_d = diff[PW-1:0];
	end

	always_ff @(posedge clk) begin
		if (issue && mem_we)
			mem[wp_q] <= cmd.ch;
		rdata_s2 <= mem[rp_q];
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			status_s2  <= status_d;
			fill_s2    <= fill_d;
			is_read_s2 <= (status_d == ST_READ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
			if (issue) begin
				wp_q <= wp_d;
				rp_q <= rp_d;
			end
		end
	end

	assign fill_ext       = {8'd0, fill_s2};
	assign res_valid      = valid_s2;
	assign res.status     = status_s2;
	assign res.character  = is_read_s2 ? rdata_s2 : 7'd0;
	assign res.fill_count = fill_ext[7:0];

endmodule

`default_nettype wire

// ----- src/scf_outq.sv -----
`default_nettype none

module scf_outq (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     res_valid,
	input  wire scf_pkg::res_t            res,
	output logic [$clog2(scf_pkg::RES_DEPTH):0] res_count,
	output logic                          empty,
	input  wire logic                     pop,
	output scf_pkg::res_t                 head
);
	import scf_pkg::*;

	localparam int AW = $clog2(RES_DEPTH);

	res_t        q_q [RES_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   count_q;
	logic          do_pop;

	assign empty     = (count_q == '0);
	assign res_count = count_q;
	assign head      = q_q[rd_q];
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_valid)
			q_q[wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (res_valid)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			count_q <= count_q + (AW + 1)'(res_valid) - (AW + 1)'(do_pop);
		end
	end

endmodule

`default_nettype wire
